[src/qkve_pkg.sv]
// shared types and constants for the query key/value extractor
package qkve_pkg;

  // tuple separator byte '&'
  localparam logic [7:0] TUPLE_SEP = 8'h26;

  // configuration register indexes (register i at byte address 8*i)
  localparam logic [2:0] REG_KEY_LENGTH     = 3'd0;
  localparam logic [2:0] REG_KEY_BYTES_0    = 3'd1;
  localparam logic [2:0] REG_KEY_BYTES_1    = 3'd2;
  localparam logic [2:0] REG_KEY_BYTES_2    = 3'd3;
  localparam logic [2:0] REG_KEY_BYTES_3    = 3'd4;
  localparam logic [2:0] REG_VALUE_CAPACITY = 3'd5;

  localparam int unsigned CFG_ADDR_W = 6;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned KEY_WORDS  = 4;
  localparam logic [8:0]  CAPACITY_RESET = 9'd64;

  typedef enum logic [3:0] {
    PH_COMPARE = 4'b0001,
    PH_SKIP    = 4'b0010,
    PH_COPY    = 4'b0100,
    PH_CLOSED  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] query_byte;
    logic       query_last;
  } in_t;

  typedef struct packed {
    logic       value_valid;
    logic [7:0] value_byte;
    logic       query_done;
    logic       found;
    logic [7:0] value_length;
  } out_t;

endpackage

[src/query_key_value_extractor_top.sv]
// query key/value extractor: byte scanner, config registers and output stage
// path: a result passes the input register and then the output register after its byte is accepted
// throughput: one query byte per cycle while the output side takes results, set by the registered scan stage
// bytes that produce no result (no value byte, not final) pass silently
// reset: synchronous active-low; scan rearms, key length 0, key bytes 0,
// value capacity 64, both pipeline stages empty
module query_key_value_extractor_top #(
  parameter int unsigned KEY_MAX_BYTES = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // query byte channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  qkve_pkg::in_t                      in_data,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output qkve_pkg::out_t                     out_data,
  // configuration port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [qkve_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [qkve_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [qkve_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic [5:0]  key_length_r;
  logic [63:0] key_bytes_r [qkve_pkg::KEY_WORDS];
  logic [8:0]  value_capacity_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  // registers sit on 8-byte boundaries; low address bits are ignored
  assign cfg_idx    = cfg_paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r     <= '0;
      key_bytes_r[0]   <= '0;
      key_bytes_r[1]   <= '0;
      key_bytes_r[2]   <= '0;
      key_bytes_r[3]   <= '0;
      value_capacity_r <= qkve_pkg::CAPACITY_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        qkve_pkg::REG_KEY_LENGTH:     key_length_r     <= cfg_pwdata[5:0];
        qkve_pkg::REG_KEY_BYTES_0:    key_bytes_r[0]   <= cfg_pwdata;
        qkve_pkg::REG_KEY_BYTES_1:    key_bytes_r[1]   <= cfg_pwdata;
        qkve_pkg::REG_KEY_BYTES_2:    key_bytes_r[2]   <= cfg_pwdata;
        qkve_pkg::REG_KEY_BYTES_3:    key_bytes_r[3]   <= cfg_pwdata;
        qkve_pkg::REG_VALUE_CAPACITY: value_capacity_r <= cfg_pwdata[8:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (cfg_idx)
      qkve_pkg::REG_KEY_LENGTH:     cfg_prdata = {58'd0, key_length_r};
      qkve_pkg::REG_KEY_BYTES_0:    cfg_prdata = key_bytes_r[0];
      qkve_pkg::REG_KEY_BYTES_1:    cfg_prdata = key_bytes_r[1];
      qkve_pkg::REG_KEY_BYTES_2:    cfg_prdata = key_bytes_r[2];
      qkve_pkg::REG_KEY_BYTES_3:    cfg_prdata = key_bytes_r[3];
      qkve_pkg::REG_VALUE_CAPACITY: cfg_prdata = {55'd0, value_capacity_r};
      default:                      cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // derived limits (the user keeps them static while a query runs; the block does not enforce it)
  // ---------------------------------------------------------------
  logic [5:0] key_len_eff;
  logic [7:0] copy_limit;

  // key lengths beyond the supported maximum act as the maximum
  assign key_len_eff = (key_length_r > 6'(KEY_MAX_BYTES)) ? 6'(KEY_MAX_BYTES)
                                                          : key_length_r;

  // capacity zero acts as one; anything past 256 saturates the copy count at 255
  always_comb begin
    if (value_capacity_r == 9'd0) begin
      copy_limit = 8'd0;
    end else if (value_capacity_r > 9'd256) begin
      copy_limit = 8'd255;
    end else begin
      copy_limit = 8'(value_capacity_r - 9'd1);
    end
  end

  // ---------------------------------------------------------------
  // input register stage
  // ---------------------------------------------------------------
  logic          s1_valid_r;
  qkve_pkg::in_t s1_data_r;
  logic          s1_adv;

  // a new byte enters when the register is empty or the held one moves on this cycle
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // ---------------------------------------------------------------
  // scan logic: one byte against one key byte, then a phase update
  // ---------------------------------------------------------------
  qkve_pkg::phase_t phase_r, phase_nxt;
  logic [5:0]       tuple_pos_r, tuple_pos_nxt;
  logic [7:0]       copied_r, copied_nxt;
  logic             emit;
  logic             is_sep;
  logic [7:0]       key_byte;
  logic [1:0]       key_word_sel;
  logic [2:0]       key_lane_sel;
  logic [63:0]      key_word;

  assign is_sep       = (s1_data_r.query_byte == qkve_pkg::TUPLE_SEP);
  assign key_word_sel = tuple_pos_r[4:3];
  assign key_lane_sel = tuple_pos_r[2:0];
  assign key_word     = key_bytes_r[key_word_sel];
  assign key_byte     = key_word[{key_lane_sel, 3'b000} +: 8];

  always_comb begin
    phase_nxt     = phase_r;
    tuple_pos_nxt = tuple_pos_r;
    copied_nxt    = copied_r;
    emit          = 1'b0;
    unique case (phase_r)
      qkve_pkg::PH_COMPARE: begin
        if (is_sep) begin
          tuple_pos_nxt = '0;
        end else if (tuple_pos_r < key_len_eff) begin
          if (s1_data_r.query_byte == key_byte) begin
            tuple_pos_nxt = tuple_pos_r + 6'd1;
          end else begin
            phase_nxt = qkve_pkg::PH_SKIP;
          end
        end else begin
          // whole key matched and the tuple goes on: this byte starts the value
          phase_nxt = qkve_pkg::PH_COPY;
          if (copied_r < copy_limit) begin
            emit       = 1'b1;
            copied_nxt = copied_r + 8'd1;
          end
        end
      end
      qkve_pkg::PH_SKIP: begin
        if (is_sep) begin
          phase_nxt     = qkve_pkg::PH_COMPARE;
          tuple_pos_nxt = '0;
        end
      end
      qkve_pkg::PH_COPY: begin
        if (is_sep) begin
          phase_nxt = qkve_pkg::PH_CLOSED;
        end else if (copied_r < copy_limit) begin
          emit       = 1'b1;
          copied_nxt = copied_r + 8'd1;
        end
      end
      qkve_pkg::PH_CLOSED: begin
        // rest of the query is ignored
      end
      default: begin
        phase_nxt = qkve_pkg::PH_COMPARE;
      end
    endcase
  end

  // ---------------------------------------------------------------
  // result build and stage advance
  // ---------------------------------------------------------------
  logic           has_result;
  logic           out_free;
  logic           out_valid_r;
  qkve_pkg::out_t out_data_r, out_data_nxt;

  assign has_result = emit || s1_data_r.query_last;
  assign out_free   = !out_valid_r || out_ready;
  // silent bytes never wait on the output side
  assign s1_adv     = s1_valid_r && (!has_result || out_free);

  always_comb begin
    out_data_nxt.value_valid  = emit;
    out_data_nxt.value_byte   = emit ? s1_data_r.query_byte : 8'd0;
    out_data_nxt.query_done   = s1_data_r.query_last;
    out_data_nxt.found        = s1_data_r.query_last &&
                                ((phase_nxt == qkve_pkg::PH_COPY) ||
                                 (phase_nxt == qkve_pkg::PH_CLOSED));
    out_data_nxt.value_length = s1_data_r.query_last ? copied_nxt : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= qkve_pkg::PH_COMPARE;
      tuple_pos_r <= '0;
      copied_r    <= '0;
    end else if (s1_adv) begin
      if (s1_data_r.query_last) begin
        // final byte rearms the scan for the next query
        phase_r     <= qkve_pkg::PH_COMPARE;
        tuple_pos_r <= '0;
        copied_r    <= '0;
      end else begin
        phase_r     <= phase_nxt;
        tuple_pos_r <= tuple_pos_nxt;
        copied_r    <= copied_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && has_result) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sim/tb_query_key_value_extractor_top.sv]
// testbench for the query key/value extractor: random and directed queries checked against a scan model
`timescale 1ns / 100ps

module tb_query_key_value_extractor_top;

  // matches the default key size of the block
  localparam int unsigned KEY_MAX = 32;
  // cycles allowed for bytes that leave no result to clear the pipeline
  localparam int unsigned SETTLE_CYCLES = 4;
  // long receiver hold-off used to back the block up
  localparam int unsigned LONG_HOLD = 150;
  localparam int unsigned PHASE_ITEMS = 130;
  localparam int unsigned RANDOM_PHASES = 10;

  // one pending query byte plus a flag that makes the sender wait for all results first
  typedef struct packed {
    qkve_pkg::in_t item;
    logic          wait_drain;
  } feed_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  qkve_pkg::in_t in_data = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  qkve_pkg::out_t out_data;

  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [qkve_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [qkve_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [qkve_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  // register copies, kept in step with every write
  logic [5:0]  key_len_cfg = '0;
  logic [63:0] key_word_cfg [qkve_pkg::KEY_WORDS] = '{default: '0};
  logic [8:0]  capacity_cfg = qkve_pkg::CAPACITY_RESET;

  // scan state of the predictor
  qkve_pkg::phase_t scan_ph = qkve_pkg::PH_COMPARE;
  int unsigned tuple_pos = 0;
  int unsigned copied_n = 0;

  feed_t          query_feed_q[$];
  qkve_pkg::out_t value_results_q[$];
  logic [7:0]     qbuild[$];

  int unsigned fed_items = 0;
  int unsigned mismatch_count = 0;
  bit in_taken = 1'b0;

  // idling knobs, changed only between phases
  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;
  bit recv_hold_req = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned recv_hold_left = 0;

  query_key_value_extractor_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // scan model
  // ------------------------------------------------------------------

  // key length above the key size acts as the key size
  function automatic int unsigned eff_key_len();
    return (key_len_cfg > KEY_MAX) ? KEY_MAX : key_len_cfg;
  endfunction

  function automatic logic [7:0] key_byte_at(input int unsigned pos);
    return key_word_cfg[pos / 8][(pos % 8) * 8 +: 8];
  endfunction

  // advances the scan by one byte; returns 1 when the byte yields a result
  function automatic bit scan_query_byte(input qkve_pkg::in_t q, output qkve_pkg::out_t r);
    int unsigned klen;
    int unsigned lim;
    bit emit;
    klen = eff_key_len();
    // capacity zero copies nothing, copies saturate at 255
    lim = (capacity_cfg == 0) ? 0 : capacity_cfg - 1;
    if (lim > 255) lim = 255;
    emit = 1'b0;
    case (scan_ph)
      qkve_pkg::PH_COMPARE: begin
        if (q.query_byte == qkve_pkg::TUPLE_SEP) begin
          tuple_pos = 0;
        end else if (tuple_pos < klen) begin
          if (q.query_byte == key_byte_at(tuple_pos)) tuple_pos++;
          else scan_ph = qkve_pkg::PH_SKIP;
        end else begin
          // first byte past a full key match starts the value
          scan_ph = qkve_pkg::PH_COPY;
          if (copied_n < lim) begin
            emit = 1'b1;
            copied_n++;
          end
        end
      end
      qkve_pkg::PH_SKIP: begin
        if (q.query_byte == qkve_pkg::TUPLE_SEP) begin
          scan_ph = qkve_pkg::PH_COMPARE;
          tuple_pos = 0;
        end
      end
      qkve_pkg::PH_COPY: begin
        if (q.query_byte == qkve_pkg::TUPLE_SEP) begin
          scan_ph = qkve_pkg::PH_CLOSED;
        end else if (copied_n < lim) begin
          emit = 1'b1;
          copied_n++;
        end
      end
      default: ;
    endcase
    r = '0;
    if (emit) begin
      r.value_valid = 1'b1;
      r.value_byte = q.query_byte;
    end
    if (q.query_last) begin
      r.query_done = 1'b1;
      r.found = (scan_ph == qkve_pkg::PH_COPY) || (scan_ph == qkve_pkg::PH_CLOSED);
      r.value_length = copied_n[7:0];
      // final byte rearms the scan for the next query
      scan_ph = qkve_pkg::PH_COMPARE;
      tuple_pos = 0;
      copied_n = 0;
    end
    return emit || q.query_last;
  endfunction

  // ------------------------------------------------------------------
  // query building
  // ------------------------------------------------------------------

  // random byte that never splits a tuple
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == qkve_pkg::TUPLE_SEP) b = 8'h3d;
    return b;
  endfunction

  function automatic logic [63:0] rand_key_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    for (int i = 0; i < 8; i++)
      if (w[i * 8 +: 8] == qkve_pkg::TUPLE_SEP) w[i * 8 +: 8] = 8'h5f;
    return w;
  endfunction

  // mostly short values, some around the copy limit (capacity up to 70) or of 7 to 20 bytes
  function automatic int unsigned pick_value_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 6);
    if (capacity_cfg <= 70)
      return $urandom_range((capacity_cfg > 2) ? capacity_cfg - 2 : 0, capacity_cfg + 2);
    return $urandom_range(7, 20);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_plain(input int unsigned len);
    repeat (len) qbuild.push_back(plain_byte());
  endtask

  // full key followed by a value of the given length
  task automatic add_match_tuple(input int unsigned vlen);
    for (int i = 0; i < eff_key_len(); i++) qbuild.push_back(key_byte_at(i));
    add_plain(vlen);
  endtask

  // key prefix that breaks off at a random position
  task automatic add_near_tuple();
    int unsigned j;
    if (eff_key_len() == 0) begin
      add_plain($urandom_range(1, 4));
    end else begin
      j = $urandom_range(0, eff_key_len() - 1);
      for (int i = 0; i < j; i++) qbuild.push_back(key_byte_at(i));
      qbuild.push_back(key_byte_at(j) ^ 8'h01);
      add_plain($urandom_range(0, 4));
    end
  endtask

  task automatic gen_query();
    int unsigned ntup;
    int unsigned kind;
    qbuild.delete();
    if ($urandom_range(0, 9) == 0) begin
      // raw noise with separators anywhere
      repeat ($urandom_range(1, 10))
        qbuild.push_back(($urandom_range(0, 3) == 0) ? qkve_pkg::TUPLE_SEP : 8'($urandom));
    end else begin
      ntup = $urandom_range(1, 4);
      if ($urandom_range(0, 7) == 0) qbuild.push_back(qkve_pkg::TUPLE_SEP);
      for (int t = 0; t < ntup; t++) begin
        if (t != 0) qbuild.push_back(qkve_pkg::TUPLE_SEP);
        kind = $urandom_range(0, 9);
        if (kind < 4) add_match_tuple(pick_value_len());
        else if (kind < 6) add_near_tuple();
        else if (kind < 8) add_plain($urandom_range(1, 6));
        else if (kind == 9) add_match_tuple(0);
        // remaining kind leaves an empty tuple
      end
    end
    if (qbuild.size() == 0) qbuild.push_back(plain_byte());
  endtask

  // hands the built query to the sender, last flag on its final byte
  task automatic push_query(input bit drain_first);
    feed_t e;
    foreach (qbuild[i]) begin
      e.item.query_byte = qbuild[i];
      e.item.query_last = (i == qbuild.size() - 1);
      e.wait_drain = drain_first && (i == 0);
      query_feed_q.push_back(e);
    end
    fed_items += qbuild.size();
  endtask

  // ------------------------------------------------------------------
  // configuration port
  // ------------------------------------------------------------------

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      qkve_pkg::REG_KEY_LENGTH:     key_len_cfg = val[5:0];
      qkve_pkg::REG_KEY_BYTES_0:    key_word_cfg[0] = val;
      qkve_pkg::REG_KEY_BYTES_1:    key_word_cfg[1] = val;
      qkve_pkg::REG_KEY_BYTES_2:    key_word_cfg[2] = val;
      qkve_pkg::REG_KEY_BYTES_3:    key_word_cfg[3] = val;
      qkve_pkg::REG_VALUE_CAPACITY: capacity_cfg = val[8:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic load_config(input int unsigned klen, input int unsigned cap);
    write_reg(qkve_pkg::REG_KEY_LENGTH, 64'(klen));
    write_reg(qkve_pkg::REG_KEY_BYTES_0, rand_key_word());
    write_reg(qkve_pkg::REG_KEY_BYTES_1, rand_key_word());
    write_reg(qkve_pkg::REG_KEY_BYTES_2, rand_key_word());
    write_reg(qkve_pkg::REG_KEY_BYTES_3, rand_key_word());
    write_reg(qkve_pkg::REG_VALUE_CAPACITY, 64'(cap));
  endtask

  // all bytes sent, all results in, then a wait for silent bytes still in flight
  task automatic settle_block();
    while (query_feed_q.size() != 0 || in_valid || value_results_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ------------------------------------------------------------------
  // sender: valid held with stable data until the transaction completes
  // ------------------------------------------------------------------
  always @(negedge clk) begin : drive_queries
    logic          nxt_valid;
    qkve_pkg::in_t nxt_data;
    nxt_valid = in_valid;
    nxt_data = in_data;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else if (!in_valid || in_taken) begin
      nxt_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (query_feed_q.size() != 0 &&
                   !(query_feed_q[0].wait_drain && value_results_q.size() != 0)) begin
        nxt_valid = 1'b1;
        nxt_data = query_feed_q[0].item;
        void'(query_feed_q.pop_front());
        send_gap = send_idle_on ? pick_gap() : 0;
      end
    end
    in_taken = 1'b0;
    in_valid <= nxt_valid;
    in_data <= nxt_data;
  end

  // ------------------------------------------------------------------
  // receiver: random stalls plus an occasional long hold-off
  // ------------------------------------------------------------------
  always @(negedge clk) begin : drive_ready
    if (recv_hold_req && recv_hold_left == 0) begin
      recv_hold_left = LONG_HOLD;
      recv_hold_req = 1'b0;
    end
    if (recv_hold_left > 0) begin
      recv_hold_left--;
      out_ready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      recv_stall = recv_idle_on ? pick_gap() : 0;
    end
  end

  // ------------------------------------------------------------------
  // monitor: check result transactions first, then predict for the accepted byte
  // ------------------------------------------------------------------
  always @(posedge clk) begin : watch_results
    qkve_pkg::out_t want;
    qkve_pkg::out_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (value_results_q.size() == 0) begin
          $error("result transaction with no expectation waiting: %h", got);
          mismatch_count++;
        end else begin
          want = value_results_q.pop_front();
          if (got.value_valid !== want.value_valid) begin
            $error("value_valid: expected %0h, actual %0h", want.value_valid, got.value_valid);
            mismatch_count++;
          end
          if (got.value_byte !== want.value_byte) begin
            $error("value_byte: expected %0h, actual %0h", want.value_byte, got.value_byte);
            mismatch_count++;
          end
          if (got.query_done !== want.query_done) begin
            $error("query_done: expected %0h, actual %0h", want.query_done, got.query_done);
            mismatch_count++;
          end
          if (got.found !== want.found) begin
            $error("found: expected %0h, actual %0h", want.found, got.found);
            mismatch_count++;
          end
          if (got.value_length !== want.value_length) begin
            $error("value_length: expected %0d, actual %0d", want.value_length,
                   got.value_length);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        if (scan_query_byte(in_data, want)) value_results_q.push_back(want);
      end
    end
  end

  // ------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------
  initial begin : run_queries
    int unsigned phase_start;
    int unsigned klen;
    int unsigned cap;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty key after reset: first non-empty tuple matches whole
    qbuild = '{qkve_pkg::TUPLE_SEP, 8'h41};
    push_query(1'b0);
    qbuild = '{8'hff};
    push_query(1'b0);
    qbuild = '{8'h00};
    push_query(1'b0);
    // lone separator, nothing found
    qbuild = '{qkve_pkg::TUPLE_SEP};
    push_query(1'b0);
    settle_block();

    // key "ab" with capacity zero: match found but nothing copied
    write_reg(qkve_pkg::REG_KEY_LENGTH, 64'd2);
    write_reg(qkve_pkg::REG_KEY_BYTES_0, 64'h6261);
    write_reg(qkve_pkg::REG_VALUE_CAPACITY, 64'd0);
    qbuild = '{8'h61, 8'h62, 8'h63};
    push_query(1'b0);
    settle_block();

    // skip, match, then everything after the closing separator ignored
    write_reg(qkve_pkg::REG_VALUE_CAPACITY, 64'd64);
    qbuild = '{8'h78, 8'h61, 8'h62, qkve_pkg::TUPLE_SEP, 8'h61, 8'h62, 8'h5a,
               qkve_pkg::TUPLE_SEP, 8'h61, 8'h62, 8'h51};
    push_query(1'b0);
    // tuple equal to the key is not a match
    qbuild = '{8'h61, 8'h62};
    push_query(1'b0);
    settle_block();

    // key holding a separator can never match
    write_reg(qkve_pkg::REG_KEY_BYTES_0, {48'h0, qkve_pkg::TUPLE_SEP, 8'h61});
    qbuild = '{8'h61, qkve_pkg::TUPLE_SEP, 8'h62};
    push_query(1'b0);
    settle_block();

    // back-pressure: receiver holds off while the sender streams a long value
    load_config(2, 128);
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    recv_hold_req = 1'b1;
    qbuild.delete();
    add_match_tuple(90);
    qbuild.push_back(qkve_pkg::TUPLE_SEP);
    add_plain(3);
    push_query(1'b0);
    repeat (3) begin
      gen_query();
      push_query(1'b0);
    end
    // sender pauses until every result is back before this query
    gen_query();
    push_query(1'b1);
    settle_block();

    // random phases over a spread of settings, extremes first
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin klen = 0;  cap = 1;   end
        1: begin klen = 1;  cap = 64;  end
        2: begin klen = 32; cap = 2;   end
        3: begin klen = 63; cap = 256; end
        4: begin klen = 33; cap = 511; end
        5: begin klen = 3;  cap = 0;   end
        6: begin klen = $urandom_range(1, 8); cap = 255; end
        default: begin
          klen = $urandom_range(0, 12);
          cap = $urandom_range(0, 80);
        end
      endcase
      load_config(klen, cap);
      send_idle_on = (ph % 3 != 1);
      recv_idle_on = (ph % 4 != 2);
      phase_start = fed_items;
      // values past 255 bytes where the capacity allows it
      if (cap >= 256) begin
        qbuild.delete();
        add_match_tuple((cap > 256) ? 300 : 270);
        push_query(1'b0);
      end
      while (fed_items - phase_start < PHASE_ITEMS) begin
        gen_query();
        push_query($urandom_range(0, 19) == 0);
      end
      settle_block();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("query_key_value_extractor_top test passed");
    end else begin
      $display("query_key_value_extractor_top test failed");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin : run_limit
    #10_000_000;
    $display("query_key_value_extractor_top test failed");
    $finish;
  end

endmodule
